FILE: rtl/srtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types, sizes and helpers for the SRTF process scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ST_ARRIVED = 2'd0,
    ST_FULL    = 2'd1,
    ST_IDLE    = 2'd2,
    ST_RAN     = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]  ident;
    logic [15:0] burst;
    logic [31:0] wait_cnt;
    logic [15:0] remain;
  } slot_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    slot_t wdata;
    logic  re;
    idx_t  raddr;
  } mem_req_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  run_id;
    logic        done_res;
    logic [3:0]  done_id;
    logic [31:0] done_wait;
    logic [31:0] done_finish;
    logic [31:0] done_turnaround;
    logic [31:0] now;
  } res_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

FILE: rtl/srtf_process_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_process_scheduler
// Shortest-remaining-time-first scheduler over a RAM of process slots.
// ----------------------------------------------------------------------------
// Timing: an arrival goes from transfer straight to the result state; a tick
//   runs a search pass over the N slots handed out so far (at most SLOTS),
//   then an update pass only when a slot runs.
// Flow: one item at a time; the input stalls until the result has been taken
//   into the output register. A tick that runs a slot makes two passes over the
//   slot RAM read port (minimum search, then wait/remaining write-back), else one.
// Reset: asynchronous, active low. Table empty, time zero, no clearing
//   pass: slots beyond the fill count are never read.
// ----------------------------------------------------------------------------
module srtf_process_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [3:0]  proc_id_i,
  input  logic [15:0] burst_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  run_id_o,
  output logic        done_res_o,
  output logic [3:0]  done_id_o,
  output logic [31:0] done_wait_o,
  output logic [31:0] done_finish_o,
  output logic [31:0] done_turnaround_o,
  output logic [31:0] now_o
);

  srtf_pkg::mem_req_t mem_req;
  srtf_pkg::slot_t    mem_rdata;
  srtf_pkg::res_t     res;
  logic               res_valid;
  logic               res_ready;

  logic               out_valid_q;
  srtf_pkg::res_t     out_q;

  // Slot table: ident, burst, wait and remaining per slot, one word each.
  srtf_slot_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Sequencer: one read per cycle during a pass, data back in the next cycle. The update pass
  // writes slot i while reading slot i+1, so no entry is read and written
  // in the same cycle.
  srtf_sched_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .proc_id_i   (proc_id_i),
    .burst_i     (burst_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register parts the two sides: the sequencer takes the next item
  // while a finished result still waits for its transfer.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign run_id_o          = out_q.run_id;
  assign done_res_o        = out_q.done_res;
  assign done_id_o         = out_q.done_id;
  assign done_wait_o       = out_q.done_wait;
  assign done_finish_o     = out_q.done_finish;
  assign done_turnaround_o = out_q.done_turnaround;
  assign now_o             = out_q.now;

endmodule

FILE: rtl/srtf_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_slot_mem
// Slot table RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srtf_slot_mem (
  input  logic               clk_i,
  input  srtf_pkg::mem_req_t req_i,
  output srtf_pkg::slot_t    rdata_o
);

  srtf_pkg::slot_t mem_q [srtf_pkg::SLOTS];
  srtf_pkg::slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/srtf_sched_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_sched_ctrl
// Command sequencer: arrival writes, min-search pass and update pass.
// ----------------------------------------------------------------------------
module srtf_sched_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [3:0]         proc_id_i,
  input  logic [15:0]        burst_i,
  output srtf_pkg::mem_req_t mem_req_o,
  input  srtf_pkg::slot_t    mem_rdata_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output srtf_pkg::res_t     res_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  state_e            state_q;
  srtf_pkg::cnt_t    used_q;
  srtf_pkg::cnt_t    rd_cnt_q;
  logic [31:0]       time_q;
  logic              dvld_q;
  srtf_pkg::idx_t    didx_q;
  logic              found_q;
  srtf_pkg::idx_t    best_idx_q;
  srtf_pkg::slot_t   best_q;
  srtf_pkg::status_e status_q;

  logic        accept;
  logic        full;
  logic        pass_active;
  logic        issue;
  logic        pass_end;
  logic        live;
  logic        better;
  logic [32:0] turn_sum;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign full        = (used_q == srtf_pkg::CNT_W'(srtf_pkg::SLOTS));
  assign pass_active = (state_q == S_SCAN) || (state_q == S_UPDATE);
  assign issue       = pass_active && (rd_cnt_q != used_q);
  assign pass_end    = pass_active && (rd_cnt_q == used_q) && !dvld_q;
  assign live        = dvld_q && (mem_rdata_i.remain != 16'd0);
  assign better      = live && (!found_q || (mem_rdata_i.remain < best_q.remain));

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESULT);

  // RAM port: arrival write in the accept cycle, write-back in the update pass
  always_comb begin
    mem_req_o       = '0;
    mem_req_o.re    = issue;
    mem_req_o.raddr = rd_cnt_q[srtf_pkg::IDX_W-1:0];
    if (accept && (cmd_i == srtf_pkg::CMD_ARRIVE) && !full) begin
      mem_req_o.we             = 1'b1;
      mem_req_o.waddr          = used_q[srtf_pkg::IDX_W-1:0];
      mem_req_o.wdata.ident    = proc_id_i;
      mem_req_o.wdata.burst    = burst_i;
      mem_req_o.wdata.wait_cnt = 32'd0;
      mem_req_o.wdata.remain   = burst_i;
    end else if ((state_q == S_UPDATE) && live) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.waddr = didx_q;
      mem_req_o.wdata = mem_rdata_i;
      if (didx_q == best_idx_q) begin
        mem_req_o.wdata.remain = mem_rdata_i.remain - 16'd1;
      end else begin
        mem_req_o.wdata.wait_cnt = srtf_pkg::sat_inc32(mem_rdata_i.wait_cnt);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      rd_cnt_q <= '0;
      time_q   <= '0;
      dvld_q   <= 1'b0;
      found_q  <= 1'b0;
      status_q <= srtf_pkg::ST_ARRIVED;
    end else begin
      dvld_q <= issue;
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + srtf_pkg::CNT_W'(1);
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (cmd_i == srtf_pkg::CMD_TICK) begin
              time_q   <= srtf_pkg::sat_inc32(time_q);
              rd_cnt_q <= '0;
              found_q  <= 1'b0;
              state_q  <= S_SCAN;
            end else begin
              if (full) begin
                status_q <= srtf_pkg::ST_FULL;
              end else begin
                status_q <= srtf_pkg::ST_ARRIVED;
                used_q   <= used_q + srtf_pkg::CNT_W'(1);
              end
              state_q <= S_RESULT;
            end
          end
        end
        S_SCAN: begin
          if (better) begin
            found_q <= 1'b1;
          end
          if (pass_end) begin
            if (found_q) begin
              status_q <= srtf_pkg::ST_RAN;
              rd_cnt_q <= '0;
              state_q  <= S_UPDATE;
            end else begin
              status_q <= srtf_pkg::ST_IDLE;
              state_q  <= S_RESULT;
            end
          end
        end
        S_UPDATE: begin
          if (pass_end) begin
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload: read tag and the running pick
  always_ff @(posedge clk_i) begin
    didx_q <= rd_cnt_q[srtf_pkg::IDX_W-1:0];
    if ((state_q == S_SCAN) && better) begin
      best_idx_q <= didx_q;
      best_q     <= mem_rdata_i;
    end
  end

  assign turn_sum = {1'b0, best_q.wait_cnt} + {17'd0, best_q.burst};

  // best_q holds the pick before its decrement: remain of one means finished
  always_comb begin
    res_o        = '0;
    res_o.status = status_q;
    res_o.now    = time_q;
    if (status_q == srtf_pkg::ST_RAN) begin
      res_o.run_id = best_q.ident;
      if (best_q.remain == 16'd1) begin
        res_o.done_res        = 1'b1;
        res_o.done_id         = best_q.ident;
        res_o.done_wait       = best_q.wait_cnt;
        res_o.done_finish     = time_q;
        res_o.done_turnaround = turn_sum[32] ? 32'hFFFF_FFFF : turn_sum[31:0];
      end
    end
  end

endmodule

FILE: rtl/srtf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtf_checker
// Port-level checks on the result channel of the scheduler.
// ----------------------------------------------------------------------------
module srtf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [3:0]  run_id_o,
  input logic        done_res_o,
  input logic [3:0]  done_id_o,
  input logic [31:0] done_finish_o,
  input logic [31:0] now_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(now_o) && $stable(status_o))
    else $error("stalled result changed");

  // one item at a time: an input transfer leaves the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // a finish only comes from a tick that ran that same process
  a_done_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |->
      (status_o == srtf_pkg::ST_RAN) && (done_id_o == run_id_o))
    else $error("finish without matching run");

  // finish time is the time after the tick
  a_finish_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> (done_finish_o == now_o))
    else $error("finish time differs from now");

  // every tick advances time, so its result never shows time zero
  a_tick_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == srtf_pkg::ST_IDLE) || (status_o == srtf_pkg::ST_RAN))
      |-> (now_o != 32'd0))
    else $error("tick result at time zero");

endmodule

bind srtf_process_scheduler srtf_checker u_chk (.*);
